/* hw/rtl/cdcs_pkg.sv */
// shared constants and types of the calibration dac code search
`default_nettype none

package cdcs_pkg;

    // sweep range
    localparam int CODE_COUNT = 1024;
    localparam int CODE_W     = $clog2(CODE_COUNT);
    localparam int DAC_W      = 10;

    // field and register widths
    localparam int COEF_W = 64;
    localparam int CAP_W  = 24;
    localparam int TGT_W  = 21;

    // charge scale: fF*V per electron times 10^9, and the matching distance scale
    localparam int                  CHARGE_W     = 18;
    localparam logic [CHARGE_W-1:0] CHARGE_SCALE = 18'd160218;
    localparam int                  DIST_W       = 20;
    localparam logic [DIST_W-1:0]   DIST_SCALE   = 20'd1000000;

    // scaled capacitance, scaled target, difference seeds
    localparam int K_W     = CAP_W + DIST_W;
    localparam int K_CNT_W = $clog2(K_W);
    localparam int T_W     = TGT_W + CHARGE_W;
    localparam int X_W     = COEF_W + 4;
    localparam int T_SHIFT = 64;

    // charge-distance datapath, holds p(v)*k - t*2^64 for v up to CODE_COUNT
    localparam int Q_W = COEF_W + 3 * CODE_W + 2 + K_W + 1;

    // configuration register indexes
    localparam int                   CFG_IDX_W    = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CUBIC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_LOW  = 3'd5;

    // difference engine register selects
    localparam logic [1:0] SEL_Q  = 2'd0;
    localparam logic [1:0] SEL_D1 = 2'd1;
    localparam logic [1:0] SEL_D2 = 2'd2;
    localparam logic [1:0] SEL_D3 = 2'd3;

    // control from the sequencer to the sweep unit
    typedef struct packed {
        logic       init;
        logic       step;
        logic       load;
        logic [1:0] sel;
    } t_sweep_ctl;

endpackage

`default_nettype wire

/* hw/rtl/cdcs_mul.sv */
// shift-add serial multiplier: signed multiplicand times unsigned multiplier plus start value
`default_nettype none

module cdcs_mul
    import cdcs_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [X_W-1:0]   i_mcand,
    input  wire logic        [K_W-1:0]   i_mplier,
    input  wire logic        [Q_W-1:0]   i_init,
    output logic                         o_done,
    output logic             [Q_W-1:0]   o_prod
);

    logic               r_busy;
    logic               r_done;
    logic [K_CNT_W-1:0] r_cnt;
    logic [Q_W-1:0]     r_acc;
    logic [Q_W-1:0]     r_mcand;
    logic [K_W-1:0]     r_mplier;

    // control: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == K_CNT_W'(K_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // datapath: one wide add of the shifted multiplicand
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= i_init;
            r_mcand  <= {{(Q_W - X_W){i_mcand[X_W-1]}}, i_mcand};
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

/* hw/rtl/cdcs_sweep.sv */
// forward-difference sweep over dac codes with distance compare and best tracking
`default_nettype none

module cdcs_sweep
    import cdcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_sweep_ctl        i_ctl,
    input  wire logic [Q_W-1:0]    i_value,
    input  wire logic [Q_W-1:0]    i_best0,
    output logic                   o_last,
    output logic [CODE_W-1:0]      o_best_code
);

    logic [Q_W-1:0]    r_q;
    logic [Q_W-1:0]    r_d1;
    logic [Q_W-1:0]    r_d2;
    logic [Q_W-1:0]    r_d3;
    logic [CODE_W-1:0] r_code;
    logic [Q_W-1:0]    r_mag;
    logic [CODE_W-1:0] r_mag_code;
    logic              r_mag_valid;
    logic [Q_W-1:0]    r_best;
    logic [CODE_W-1:0] r_best_code;
    logic [Q_W-1:0]    q_abs;

    assign q_abs = r_q[Q_W-1] ? (~r_q + 1'b1) : r_q;

    // difference registers: loaded from the multiplier, then stepped once per code
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            case (i_ctl.sel)
                SEL_Q:   r_q  <= i_value;
                SEL_D1:  r_d1 <= i_value;
                SEL_D2:  r_d2 <= i_value;
                default: r_d3 <= i_value;
            endcase
        end else if (i_ctl.step) begin
            r_q  <= r_q + r_d1;
            r_d1 <= r_d1 + r_d2;
            r_d2 <= r_d2 + r_d3;
        end
    end

    // code counter and magnitude stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code      <= '0;
            r_mag_valid <= 1'b0;
        end else begin
            r_mag_valid <= i_ctl.step;
            if (i_ctl.init) begin
                r_code <= '0;
            end else if (i_ctl.step) begin
                r_code <= r_code + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_mag      <= q_abs;
            r_mag_code <= r_code;
        end
    end

    // strict compare keeps the lowest code on ties
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_best      <= i_best0;
            r_best_code <= '0;
        end else if (r_mag_valid && (r_mag < r_best)) begin
            r_best      <= r_mag;
            r_best_code <= r_mag_code;
        end
    end

    assign o_last      = (r_code == CODE_W'(CODE_COUNT - 1));
    assign o_best_code = r_best_code;

endmodule

`default_nettype wire

/* hw/rtl/calib_dac_code_search_top.sv */
// calibration dac code search: top level with registers, sequencer and output register
//
// A request carries a target charge in electrons and a capacitor select. The block
// finds the first dac code whose injected charge (cubic voltage curve times the
// selected capacitance) lies closest to the target and returns it as one result.
// Input channel: i_in_valid / o_in_stall; the block stalls while a request is at work.
// Output channel: o_out_valid / i_out_stall; the result sits in an output register
// and holds until taken, and a new request may be accepted meanwhile.
// Four serial 44-step multiplies seed a forward-difference engine, whose sweep steps
// one code per cycle over all CODE_COUNT (1024) codes; a prep state comes before and
// a drain state after. The block takes no new request until the previous result has
// moved to the output register. If the previous result is still stalled at the end
// of a sweep, the block waits. Configuration is written through i_cfg_we /
// i_cfg_index / i_cfg_data; the user must do so only while idle, which the block
// itself does not enforce. Unknown indexes are ignored. Synchronous reset clears the
// configuration and control registers, leaving the block idle with no result pending.
`default_nettype none

module calib_dac_code_search_top
    import cdcs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [COEF_W-1:0]      i_cfg_data,
    // request
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_cap_select,
    input  wire logic signed [TGT_W-1:0] i_target_charge,
    // result
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [DAC_W-1:0]            o_dac_code
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_MSTART = 3'd2;
    localparam logic [2:0] ST_MWAIT  = 3'd3;
    localparam logic [2:0] ST_SWEEP  = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic signed [COEF_W-1:0] r_coeff_cubic;
    logic signed [COEF_W-1:0] r_coeff_square;
    logic signed [COEF_W-1:0] r_coeff_linear;
    logic signed [COEF_W-1:0] r_coeff_offset;
    logic [CAP_W-1:0]         r_cap_high_ff;
    logic [CAP_W-1:0]         r_cap_low_ff;

    logic [2:0]               r_state;
    logic [1:0]               r_idx;
    logic                     r_cap_sel;
    logic signed [TGT_W-1:0]  r_target;
    logic [K_W-1:0]           r_k;
    logic signed [T_W-1:0]    r_t;
    logic                     r_out_valid;
    logic [DAC_W-1:0]         r_dac_code;

    logic signed [T_W-1:0]    t_prod;
    logic [T_W-1:0]           t_mag;
    logic [Q_W-1:0]           t_ext;
    logic [Q_W-1:0]           best0;
    logic [Q_W-1:0]           mul_init;
    logic signed [X_W-1:0]    a_ext;
    logic signed [X_W-1:0]    b_ext;
    logic signed [X_W-1:0]    c_ext;
    logic signed [X_W-1:0]    d_ext;
    logic signed [X_W-1:0]    a_six;
    logic signed [X_W-1:0]    mcand;
    logic                     mul_start;
    logic                     mul_done;
    logic [Q_W-1:0]           mul_prod;
    t_sweep_ctl               sweep_ctl;
    logic                     sweep_last;
    logic [CODE_W-1:0]        best_code;
    logic                     out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_cubic  <= '0;
            r_coeff_square <= '0;
            r_coeff_linear <= '0;
            r_coeff_offset <= '0;
            r_cap_high_ff  <= '0;
            r_cap_low_ff   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CUBIC:    r_coeff_cubic  <= i_cfg_data;
                REG_SQUARE:   r_coeff_square <= i_cfg_data;
                REG_LINEAR:   r_coeff_linear <= i_cfg_data;
                REG_OFFSET:   r_coeff_offset <= i_cfg_data;
                REG_CAP_HIGH: r_cap_high_ff  <= i_cfg_data[CAP_W-1:0];
                REG_CAP_LOW:  r_cap_low_ff   <= i_cfg_data[CAP_W-1:0];
                default:      ;
            endcase
        end
    end

    // forward-difference seeds: p(0)=d, d1=a+b+c, d2=6a+2b, d3=6a
    assign a_ext = {{(X_W - COEF_W){r_coeff_cubic[COEF_W-1]}}, r_coeff_cubic};
    assign b_ext = {{(X_W - COEF_W){r_coeff_square[COEF_W-1]}}, r_coeff_square};
    assign c_ext = {{(X_W - COEF_W){r_coeff_linear[COEF_W-1]}}, r_coeff_linear};
    assign d_ext = {{(X_W - COEF_W){r_coeff_offset[COEF_W-1]}}, r_coeff_offset};
    assign a_six = (a_ext <<< 2) + (a_ext <<< 1);

    always_comb begin
        case (r_idx)
            SEL_Q:   mcand = d_ext;
            SEL_D1:  mcand = a_ext + b_ext + c_ext;
            SEL_D2:  mcand = a_six + (b_ext <<< 1);
            default: mcand = a_six;
        endcase
    end

    // scaled target and its magnitude, both shifted up to the product scale
    assign t_prod   = T_W'(r_target) * T_W'($signed({1'b0, CHARGE_SCALE}));
    assign t_mag    = r_t[T_W-1] ? (~r_t + 1'b1) : r_t;
    assign t_ext    = {{(Q_W - T_W){r_t[T_W-1]}}, r_t} << T_SHIFT;
    assign best0    = {{(Q_W - T_W){1'b0}}, t_mag} << T_SHIFT;
    assign mul_init = (r_idx == SEL_Q) ? (~t_ext + 1'b1) : '0;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_idx   <= SEL_Q;
                    r_state <= ST_MSTART;
                end
                ST_MSTART: begin
                    r_state <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (mul_done) begin
                        if (r_idx == SEL_D3) begin
                            r_state <= ST_SWEEP;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_MSTART;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (sweep_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // request capture and setup products
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_cap_sel <= i_cap_select;
            r_target  <= i_target_charge;
        end
        if (r_state == ST_PREP) begin
            r_k <= K_W'(r_cap_sel ? r_cap_high_ff : r_cap_low_ff) * K_W'(DIST_SCALE);
            r_t <= t_prod;
        end
    end

    assign mul_start = (r_state == ST_MSTART);

    always_comb begin
        sweep_ctl.init = (r_state == ST_MSTART) && (r_idx == SEL_Q);
        sweep_ctl.step = (r_state == ST_SWEEP);
        sweep_ctl.load = (r_state == ST_MWAIT) && mul_done;
        sweep_ctl.sel  = r_idx;
    end

    cdcs_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mcand),
        .i_mplier (r_k),
        .i_init   (mul_init),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    cdcs_sweep u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (sweep_ctl),
        .i_value     (mul_prod),
        .i_best0     (best0),
        .o_last      (sweep_last),
        .o_best_code (best_code)
    );

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FINISH) && out_free) begin
            r_dac_code <= DAC_W'(best_code);
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_dac_code  = r_dac_code;

`ifndef SYNTHESIS
    // an accepted request makes the block busy on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but block not busy");

    // a new result only comes out of the finish step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == ST_FINISH))
        else $error("result raised outside the finish step");

    // the multiplier finishes only while the sequencer waits for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_MWAIT))
        else $error("multiplier done outside its wait state");

    // the sweep never steps while seeds are loading
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sweep_ctl.step && (sweep_ctl.load || sweep_ctl.init)))
        else $error("sweep step overlaps seed load");
`endif

endmodule

`default_nettype wire
